[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the compositor RTL
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[rtl/tgoc_pkg.sv]
// ----------------------------------------------------------------------------
// tgoc_pkg
// Types, constants and helpers of the tinted glyph over compositor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tgoc_pkg;

	// RGBA8888 pixel, R 31:24, G 23:16, B 15:8, A 7:0
	typedef logic [31:0] pix_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	// Mode codes
	localparam logic [1:0] MODE_FILL  = 2'd0;
	localparam logic [1:0] MODE_GLYPH = 2'd1;
	localparam logic [1:0] MODE_BOTH  = 2'd2;
	localparam logic [1:0] MODE_PLAIN = 2'd3;

	// Control of one over unit
	typedef struct packed {
		logic valid;
		logic skip;  // stage not used by this mode
		logic ovr;   // copy source unconditionally
	} ovr_ctl_t;

	// Exact floor(x / 255) for x up to 65025
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
		return t[15:8];
	endfunction

endpackage
`default_nettype wire

[rtl/tinted_glyph_over_compositor_top.sv]
// ----------------------------------------------------------------------------
// tinted_glyph_over_compositor_top
// Input word to output word passes the tint register, two six-stage over
// units and the output register. Throughput: one word per cycle unless the
// output word stalls, set by the fully pipelined over units. All stages
// advance together and hold while the output word waits. Reset clears every
// valid bit at once; the block accepts words from the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tinted_glyph_over_compositor_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// mode[1:0], dest_pixel[33:2], src_pixel[65:34], fg_color[97:66],
	// bg_color[129:98], zero fill [135:130]
	input  wire logic [135:0]  s_tdata,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// out_pixel[31:0]
	output logic [31:0]        m_tdata,
	// changed[0]
	output logic               m_tuser
);

	logic            en;
	logic [1:0]      mode_w;
	tgoc_pkg::pix_t  dest_w, src_w, fg_w, bg_w, tint_w;
	logic [15:0]     cov_w;

	logic            v_s1;
	logic [1:0]      mode_s1;
	tgoc_pkg::pix_t  dest_s1, bg_s1, tint_s1;

	tgoc_pkg::ovr_ctl_t ctl_a, ctl_b;
	logic            va, wa, vb, wb;
	tgoc_pkg::pix_t  da, db;
	logic [32:0]     ca;
	logic            cb;

	logic            out_v_q, out_chg_q;
	tgoc_pkg::pix_t  out_pix_q;

	// Advance the whole pipe unless the output word is stalled
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// Unpack and tint the glyph pixel
	always_comb begin
		mode_w = s_tdata[1:0];
		dest_w = s_tdata[33:2];
		src_w  = s_tdata[65:34];
		fg_w   = s_tdata[97:66];
		bg_w   = s_tdata[129:98];
		cov_w  = 16'(fg_w[7:0]) * 16'(src_w[7:0]);
		if (src_w[7:0] == tgoc_pkg::ALPHA_OPAQUE) begin
			tint_w = fg_w;
		end else if (src_w[7:0] == tgoc_pkg::ALPHA_CLEAR) begin
			tint_w = src_w;
		end else begin
			tint_w = {fg_w[31:8], tgoc_pkg::div255(cov_w)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_w;
			dest_s1 <= dest_w;
			bg_s1   <= bg_w;
			tint_s1 <= tint_w;
		end
	end

	// Fill stage: background over destination, plain copy, or destination kept in glyph mode
	always_comb begin
		ctl_a.valid = v_s1;
		ctl_a.skip  = mode_s1 == tgoc_pkg::MODE_GLYPH;
		ctl_a.ovr   = mode_s1 == tgoc_pkg::MODE_PLAIN;
		ctl_b.valid = va;
		ctl_b.skip  = !ca[0];
		ctl_b.ovr   = 1'b0;
	end

	tgoc_over #(.CW(33)) u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl    (ctl_a),
		.s      (bg_s1),
		.d      (dest_s1),
		.cin    ({tint_s1, mode_s1 == tgoc_pkg::MODE_GLYPH || mode_s1 == tgoc_pkg::MODE_BOTH}),
		.vld    (va),
		.d_out  (da),
		.wrote  (wa),
		.cout   (ca)
	);

	// Glyph stage: tinted glyph over the fill result
	tgoc_over #(.CW(1)) u_glyph (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl    (ctl_b),
		.s      (ca[32:1]),
		.d      (da),
		.cin    (wa),
		.vld    (vb),
		.d_out  (db),
		.wrote  (wb),
		.cout   (cb)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= vb;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pix_q <= db;
			out_chg_q <= wb || cb;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = out_chg_q;

endmodule
`default_nettype wire

[rtl/tgoc_over.sv]
// ----------------------------------------------------------------------------
// tgoc_over
// Pipelined straight-alpha over unit: products, numerators, then a
// restoring divider that retires two quotient bits per stage. Six stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tgoc_over #(
	parameter int CW = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire tgoc_pkg::ovr_ctl_t   ctl,
	input  wire tgoc_pkg::pix_t       s,
	input  wire tgoc_pkg::pix_t       d,
	input  wire logic [CW-1:0]        cin,
	output logic                      vld,
	output tgoc_pkg::pix_t            d_out,
	output logic                      wrote,
	output logic [CW-1:0]             cout
);

	localparam int NDIV = 4;

	typedef struct packed {
		logic           act;
		logic           full;
		tgoc_pkg::pix_t s;
		tgoc_pkg::pix_t d;
		logic [15:0]    outa;
		logic [7:0]     alpha;
	} ovr_pl_t;

	// Two restoring steps, quotient bits bh and bh-1
	function automatic logic [32:0] div_step2(input logic [24:0] r_in,
			input logic [7:0] q_in, input logic [15:0] dv, input logic [2:0] bh);
		logic [24:0] r;
		logic [24:0] sh;
		logic [7:0]  q;
		r = r_in;
		q = q_in;
		sh = 25'(dv) << bh;
		if (r >= sh) begin
			r = r - sh;
			q[bh] = 1'b1;
		end
		sh = 25'(dv) << (bh - 3'd1);
		if (r >= sh) begin
			r = r - sh;
			q[bh - 3'd1] = 1'b1;
		end
		return {r, q};
	endfunction

	logic [7:0]  as_w, ad_w, nas_w;
	logic [15:0] csas_w [0:2];
	logic [15:0] cdad_w [0:2];
	logic [15:0] as255_w, adnas_w;

	logic                 v_s1, act_s1, full_s1;
	tgoc_pkg::pix_t       s_s1, d_s1;
	logic [CW-1:0]        cin_s1;
	logic [15:0]          csas_s1 [0:2];
	logic [15:0]          cdad_s1 [0:2];
	logic [15:0]          as255_s1, adnas_s1;
	logic [7:0]           nas_s1;

	logic [24:0]  num_w [0:2];
	logic [15:0]  outa_w;
	ovr_pl_t      pl_w;

	// Per-stage arrays, index 0 is the numerator stage
	logic          v_s   [0:NDIV];
	ovr_pl_t       pl_s  [0:NDIV];
	logic [CW-1:0] cin_s [0:NDIV];
	logic [24:0]   rem_s [0:NDIV][0:2];
	logic [7:0]    q_s   [0:NDIV][0:2];
	logic [24:0]   rem_n [0:NDIV-1][0:2];
	logic [7:0]    q_n   [0:NDIV-1][0:2];

	// Stage 1: byte products
	always_comb begin
		as_w    = s[7:0];
		ad_w    = d[7:0];
		nas_w   = tgoc_pkg::ALPHA_OPAQUE - as_w;
		as255_w = 16'(as_w) * 16'd255;
		adnas_w = 16'(ad_w) * 16'(nas_w);
		for (int c = 0; c < 3; c++) begin
			csas_w[c] = 16'(s[31-8*c -: 8]) * 16'(as_w);
			cdad_w[c] = 16'(d[31-8*c -: 8]) * 16'(ad_w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= !ctl.skip && (ctl.ovr || as_w != tgoc_pkg::ALPHA_CLEAR);
			full_s1  <= ctl.ovr || as_w == tgoc_pkg::ALPHA_OPAQUE;
			s_s1     <= s;
			d_s1     <= d;
			cin_s1   <= cin;
			as255_s1 <= as255_w;
			adnas_s1 <= adnas_w;
			nas_s1   <= nas_w;
			csas_s1  <= csas_w;
			cdad_s1  <= cdad_w;
		end
	end

	// Stage 2: numerators, output alpha and its byte
	always_comb begin
		outa_w = as255_s1 + adnas_s1;
		for (int c = 0; c < 3; c++) begin
			num_w[c] = 25'({csas_s1[c], 8'h00}) - 25'(csas_s1[c])
				+ 25'(24'(cdad_s1[c]) * 24'(nas_s1));
		end
		pl_w.act   = act_s1;
		pl_w.full  = full_s1;
		pl_w.s     = s_s1;
		pl_w.d     = d_s1;
		pl_w.outa  = outa_w;
		pl_w.alpha = tgoc_pkg::div255(outa_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[0]  <= pl_w;
			cin_s[0] <= cin_s1;
			for (int c = 0; c < 3; c++) begin
				rem_s[0][c] <= num_w[c];
				q_s[0][c]   <= 8'h00;
			end
		end
	end

	// Divider stages: two quotient bits each, high bits first
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		always_comb begin
			for (int c = 0; c < 3; c++) begin
				{rem_n[k][c], q_n[k][c]} = div_step2(rem_s[k][c], q_s[k][c],
					pl_s[k].outa, 3'(7 - 2*k));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_s[k+1]  <= pl_s[k];
				cin_s[k+1] <= cin_s[k];
				rem_s[k+1] <= rem_n[k];
				q_s[k+1]   <= q_n[k];
			end
		end
	end

	// Select kept, copied or blended pixel
	always_comb begin
		if (!pl_s[NDIV].act) begin
			d_out = pl_s[NDIV].d;
		end else if (pl_s[NDIV].full) begin
			d_out = pl_s[NDIV].s;
		end else begin
			d_out = {q_s[NDIV][0], q_s[NDIV][1], q_s[NDIV][2], pl_s[NDIV].alpha};
		end
	end

	assign vld   = v_s[NDIV];
	assign wrote = pl_s[NDIV].act;
	assign cout  = cin_s[NDIV];

	`ASSERT_NEXT(a_valid_moves, clk, arst_n, en && v_s1, v_s[0])
	`ASSERT_IMPLY(a_rem_below_div, clk, arst_n, v_s[NDIV] && pl_s[NDIV].act && !pl_s[NDIV].full, rem_s[NDIV][0] < 25'(pl_s[NDIV].outa) && rem_s[NDIV][1] < 25'(pl_s[NDIV].outa) && rem_s[NDIV][2] < 25'(pl_s[NDIV].outa))
	`ASSERT_IMPLY(a_blend_alpha_nz, clk, arst_n, v_s[NDIV] && pl_s[NDIV].act && !pl_s[NDIV].full, pl_s[NDIV].alpha != tgoc_pkg::ALPHA_CLEAR)

endmodule
`default_nettype wire
